// ===== sv/pcm_pkg.sv =====
`timescale 1ns / 1ps

package pcm_pkg;

  // Default sizes of the weight table and the accumulator bank.
  localparam int DEF_MAX_OUTPUTS  = 64;
  localparam int DEF_MAX_CHANNELS = 64;

  // Fixed field widths.
  localparam int IDX_W   = 6;
  localparam int VALUE_W = 16;
  localparam int PROD_W  = 2 * VALUE_W;
  localparam int SUM_W   = 38;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUTS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'd1;

  // Input item kinds carried in tuser.
  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // One multiply-accumulate step issued by the sequencer.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] n;
    logic             accv;
  } mac_issue_t;

  // Accumulator write-back from the multiply-accumulate pipeline.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [SUM_W-1:0] data;
  } acc_wr_t;

  // One accumulator read issued for emission.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] ch;
    logic             last;
    logic             accv;
  } emit_req_t;

  // One result beat.
  typedef struct packed {
    logic [IDX_W-1:0] ch;
    logic [SUM_W-1:0] sum;
    logic             last;
  } out_beat_t;

endpackage

// ===== sv/pcm_ram.sv =====
`timescale 1ns / 1ps

module pcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pcm_mac.sv =====
`timescale 1ns / 1ps

module pcm_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  pcm_pkg::mac_issue_t                 issue,
  input  logic signed [pcm_pkg::VALUE_W-1:0]  x,
  input  logic [pcm_pkg::VALUE_W-1:0]         w_rdata,
  input  logic [pcm_pkg::SUM_W-1:0]           a_rdata,
  output pcm_pkg::acc_wr_t                    wr,
  output logic                                busy
);

  logic                                s1_valid;
  logic [pcm_pkg::IDX_W-1:0]           s1_n;
  logic                                s1_accv;
  logic                                s2_valid;
  logic [pcm_pkg::IDX_W-1:0]           s2_n;
  logic [pcm_pkg::SUM_W-1:0]           s2_acc;
  logic signed [pcm_pkg::PROD_W-1:0]   prod;

  // Stage one waits for the RAM reads; stage two holds the product.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue.valid;
      s2_valid <= s1_valid;
    end
    s1_n    <= issue.n;
    s1_accv <= issue.accv;
    s2_n    <= s1_n;
    s2_acc  <= s1_accv ? a_rdata : '0;
    prod    <= $signed(w_rdata) * x;
  end

  // Add the sign-extended product and write the sum back.
  always_comb begin
    wr.we   = s2_valid;
    wr.addr = s2_n;
    wr.data = s2_acc + {{(pcm_pkg::SUM_W - pcm_pkg::PROD_W){prod[pcm_pkg::PROD_W-1]}}, prod};
  end

  assign busy = s1_valid | s2_valid;

endmodule

// ===== sv/pcm_out.sv =====
`timescale 1ns / 1ps

module pcm_out (
  input  logic                       clk,
  input  logic                       rst,
  input  pcm_pkg::emit_req_t         req,
  input  logic [pcm_pkg::SUM_W-1:0]  rdata,
  input  logic                       tready,
  output logic                       tvalid,
  output pcm_pkg::out_beat_t         beat,
  output logic                       can_take
);

  logic                      pend;
  logic [pcm_pkg::IDX_W-1:0] pend_ch;
  logic                      pend_last;
  logic                      pend_accv;
  logic                      ov;
  logic                      sv;
  pcm_pkg::out_beat_t        out_beat;
  pcm_pkg::out_beat_t        skid_beat;
  pcm_pkg::out_beat_t        in_beat;
  logic                      pop;
  logic [1:0]                occ;

  // The read issued last cycle shows up now as the incoming beat.
  always_comb begin
    in_beat.ch   = pend_ch;
    in_beat.sum  = pend_accv ? rdata : '0;
    in_beat.last = pend_last;
  end

  assign pop = ov & tready;

  // Two holding slots: room for a new read once this cycle settles.
  always_comb begin
    occ = 2'(ov) + 2'(sv) + 2'(pend) - 2'(pop);
    can_take = (occ < 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      ov   <= 1'b0;
      sv   <= 1'b0;
    end else begin
      pend <= req.valid;
      if (pop) begin
        if (sv) begin
          out_beat <= skid_beat;
          if (pend) begin
            skid_beat <= in_beat;
          end else begin
            sv <= 1'b0;
          end
        end else if (pend) begin
          out_beat <= in_beat;
        end else begin
          ov <= 1'b0;
        end
      end else if (pend) begin
        if (!ov) begin
          out_beat <= in_beat;
          ov       <= 1'b1;
        end else begin
          skid_beat <= in_beat;
          sv        <= 1'b1;
        end
      end
    end
    pend_ch   <= req.ch;
    pend_last <= req.last;
    pend_accv <= req.accv;
  end

  assign tvalid = ov;
  assign beat   = out_beat;

endmodule

// ===== sv/pointwise_channel_mix.sv =====
`timescale 1ns / 1ps
// Weight write beat: taken while s_axis_tready is high, which stays high after it.
// Sample beat: tready is low while the sweep runs (weight and accumulator RAM read, multiply,
// add and write back, one output channel per cycle), so no new sample is taken until it ends.
// On the last channel the result beats follow the sweep, one beat per cycle while the
// output is not stalled, and tready returns once the last accumulator read is issued.
// Reset sets both counts to 1 and clears the accumulator valid bits at once; weights stay.
module pointwise_channel_mix #(
  parameter int MAX_OUTPUTS  = pcm_pkg::DEF_MAX_OUTPUTS,
  parameter int MAX_CHANNELS = pcm_pkg::DEF_MAX_CHANNELS
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [pcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcm_pkg::CFG_W-1:0]       cfg_data,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: out_index[5:0], in_index[11:6], value[27:12], zero fill [31:28].
  input  logic [31:0]                     s_axis_tdata,
  // tuser: op[0].
  input  logic                            s_axis_tuser,
  // Output stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: out_channel[5:0], sum[43:6], zero fill [47:44].
  output logic [47:0]                     m_axis_tdata,
  output logic                            m_axis_tlast
);

  localparam int CH_LIM  = (MAX_CHANNELS < 64) ? MAX_CHANNELS : 64;
  localparam int W_DEPTH = MAX_OUTPUTS * CH_LIM;
  localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int OA_W    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int CW      = pcm_pkg::CFG_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                          state;
  logic [CW-1:0]                       outputs_in_use;
  logic [CW-1:0]                       channels_in_use;
  logic [CW-1:0]                       nout_r;
  logic [CW-1:0]                       n;
  logic                                last_ch;
  logic signed [pcm_pkg::VALUE_W-1:0]  x;
  logic [WA_W-1:0]                     wrow;
  logic [MAX_OUTPUTS-1:0]              acc_vld;

  logic                                accept;
  logic [pcm_pkg::IDX_W-1:0]           in_oi;
  logic [pcm_pkg::IDX_W-1:0]           in_ii;
  logic [pcm_pkg::VALUE_W-1:0]         in_val;
  logic [CW-1:0]                       nout_eff;
  logic [CW-1:0]                       nch_eff;
  logic                                w_we;
  logic [WA_W-1:0]                     w_waddr;
  logic [pcm_pkg::VALUE_W-1:0]         w_rdata;
  logic [pcm_pkg::SUM_W-1:0]           a_rdata;
  pcm_pkg::mac_issue_t                 issue;
  pcm_pkg::acc_wr_t                    acc_wr;
  pcm_pkg::emit_req_t                  ereq;
  pcm_pkg::out_beat_t                  beat;
  logic                                mac_busy;
  logic                                can_take;
  logic                                emit_final;

  // Unpack the input beat.
  assign in_oi  = s_axis_tdata[5:0];
  assign in_ii  = s_axis_tdata[11:6];
  assign in_val = s_axis_tdata[27:12];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;

  // Effective counts: zero acts as one, large values clamp to the limit.
  always_comb begin
    if (outputs_in_use == '0) begin
      nout_eff = CW'(1);
    end else if (outputs_in_use > CW'(MAX_OUTPUTS)) begin
      nout_eff = CW'(MAX_OUTPUTS);
    end else begin
      nout_eff = outputs_in_use;
    end
    if (channels_in_use == '0) begin
      nch_eff = CW'(1);
    end else if (channels_in_use > CW'(CH_LIM)) begin
      nch_eff = CW'(CH_LIM);
    end else begin
      nch_eff = channels_in_use;
    end
  end

  // Weight writes land in rows of CH_LIM entries per output channel.
  always_comb begin
    w_we = accept && (s_axis_tuser == pcm_pkg::OP_WEIGHT) &&
           (int'(in_oi) < MAX_OUTPUTS) && (int'(in_ii) < CH_LIM);
    w_waddr = WA_W'(int'(in_oi) * CH_LIM + int'(in_ii));
  end

  // Issue one multiply-accumulate step, or one emission read while the output can take it, per cycle.
  always_comb begin
    issue.valid = (state == ST_MAC) && (n < nout_r);
    issue.n     = n[pcm_pkg::IDX_W-1:0];
    issue.accv  = acc_vld[n[OA_W-1:0]];
    emit_final  = (n == nout_r - CW'(1));
    ereq.valid  = (state == ST_EMIT) && (n < nout_r) && can_take;
    ereq.ch     = n[pcm_pkg::IDX_W-1:0];
    ereq.last   = emit_final;
    ereq.accv   = acc_vld[n[OA_W-1:0]];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      outputs_in_use  <= CW'(1);
      channels_in_use <= CW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        pcm_pkg::REG_OUTPUTS:  outputs_in_use  <= cfg_data;
        pcm_pkg::REG_CHANNELS: channels_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: idle, multiply-accumulate sweep, emission sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      n       <= '0;
      acc_vld <= '0;
    end else begin
      if (acc_wr.we) begin
        acc_vld[acc_wr.addr[OA_W-1:0]] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (s_axis_tuser == pcm_pkg::OP_SAMPLE) &&
              (CW'(in_ii) < nch_eff)) begin
            state <= ST_MAC;
            n     <= '0;
          end
        end
        ST_MAC: begin
          if (issue.valid) begin
            n <= n + CW'(1);
          end else if (!mac_busy) begin
            n     <= '0;
            state <= last_ch ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (ereq.valid) begin
            n <= n + CW'(1);
            if (emit_final) begin
              state   <= ST_IDLE;
              acc_vld <= '0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Per-sample operands and the weight row pointer.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      x       <= $signed(in_val);
      last_ch <= (CW'(in_ii) == nch_eff - CW'(1));
      nout_r  <= nout_eff;
      wrow    <= WA_W'(in_ii);
    end else if (issue.valid) begin
      wrow <= wrow + WA_W'(CH_LIM);
    end
  end

  pcm_ram #(
    .WIDTH (pcm_pkg::VALUE_W),
    .DEPTH (W_DEPTH)
  ) u_weights (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (in_val),
    .raddr (wrow),
    .rdata (w_rdata)
  );

  pcm_ram #(
    .WIDTH (pcm_pkg::SUM_W),
    .DEPTH (MAX_OUTPUTS)
  ) u_accs (
    .clk   (clk),
    .we    (acc_wr.we),
    .waddr (acc_wr.addr[OA_W-1:0]),
    .wdata (acc_wr.data),
    .raddr (n[OA_W-1:0]),
    .rdata (a_rdata)
  );

  pcm_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .issue   (issue),
    .x       (x),
    .w_rdata (w_rdata),
    .a_rdata (a_rdata),
    .wr      (acc_wr),
    .busy    (mac_busy)
  );

  pcm_out u_out (
    .clk      (clk),
    .rst      (rst),
    .req      (ereq),
    .rdata    (a_rdata),
    .tready   (m_axis_tready),
    .tvalid   (m_axis_tvalid),
    .beat     (beat),
    .can_take (can_take)
  );

  // Pack the result beat.
  assign m_axis_tdata = {4'b0000, beat.sum, beat.ch};
  assign m_axis_tlast = beat.last;

endmodule

// ===== tb/pcm_sum_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams and the register port of the pointwise mixer. It keeps
// its own copy of the weights, accumulators and counts, predicts every result
// beat, and compares each beat taken from the output with the oldest sum due.
module pcm_sum_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // tdata: out_index[5:0], in_index[11:6], value[27:12], zero fill [31:28].
  input  logic [31:0]                   s_axis_tdata,
  // tuser: op[0].
  input  logic                          s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: out_channel[5:0], sum[43:6], zero fill [47:44].
  input  logic [47:0]                   m_axis_tdata,
  input  logic                          m_axis_tlast,
  output int                            mismatches,
  output int                            sums_pending
);

  import pcm_pkg::*;

  localparam int TABLE_DIM = 64;

  logic [VALUE_W-1:0] weight_mem [0:TABLE_DIM-1][0:TABLE_DIM-1];
  logic [SUM_W-1:0]   acc_bank [0:TABLE_DIM-1];
  logic [CFG_W-1:0]   outputs_reg;
  logic [CFG_W-1:0]   channels_reg;
  out_beat_t          sums_due [$];

  // A count of zero acts as one; anything above the table size saturates.
  function automatic int clamp_count(input logic [CFG_W-1:0] r, input int lim);
    if (r == '0) return 1;
    if (int'(r) > lim) return lim;
    return int'(r);
  endfunction

  // Apply one accepted input beat: store a weight, or accumulate a sample and,
  // on the last channel in use, queue one sum per output channel.
  task automatic take_in_beat();
    logic [IDX_W-1:0]          oi;
    logic [IDX_W-1:0]          ii;
    logic signed [VALUE_W-1:0] x;
    logic signed [VALUE_W-1:0] w;
    logic signed [PROD_W-1:0]  prod;
    int                        nout;
    int                        nch;
    out_beat_t                 b;
    oi = s_axis_tdata[5:0];
    ii = s_axis_tdata[11:6];
    x  = s_axis_tdata[27:12];
    if (s_axis_tuser == OP_WEIGHT) begin
      weight_mem[oi][ii] = x;
      return;
    end
    nout = clamp_count(outputs_reg, TABLE_DIM);
    nch  = clamp_count(channels_reg, TABLE_DIM);
    if (int'(ii) >= nch) return;
    for (int n = 0; n < nout; n++) begin
      w = weight_mem[n][ii];
      prod = w * x;
      acc_bank[n] = acc_bank[n] + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
    if (int'(ii) != nch - 1) return;
    for (int n = 0; n < nout; n++) begin
      b.ch   = IDX_W'(n);
      b.sum  = acc_bank[n];
      b.last = (n == nout - 1);
      sums_due.push_back(b);
    end
    for (int n = 0; n < TABLE_DIM; n++) acc_bank[n] = '0;
  endtask

  // Compare one result beat with the oldest sum due.
  task automatic check_out_beat();
    out_beat_t want;
    out_beat_t got;
    got.ch   = m_axis_tdata[5:0];
    got.sum  = m_axis_tdata[43:6];
    got.last = m_axis_tlast;
    if (sums_due.size() == 0) begin
      $display("%0t: result beat with no sum due: out_channel %0d sum %0d last %0b",
               $time, got.ch, $signed(got.sum), got.last);
      mismatches++;
      return;
    end
    want = sums_due.pop_front();
    if (got.ch !== want.ch) begin
      $display("%0t: out_channel expected %0d actual %0d", $time, want.ch, got.ch);
      mismatches++;
    end
    if (got.sum !== want.sum) begin
      $display("%0t: sum of out_channel %0d expected %0d actual %0d",
               $time, want.ch, $signed(want.sum), $signed(got.sum));
      mismatches++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last of out_channel %0d expected %0b actual %0b",
               $time, want.ch, want.last, got.last);
      mismatches++;
    end
  endtask

  // Outputs are compared before the input of the same edge is applied, since
  // a sample can never produce a result at the edge it is taken.
  always @(posedge clk) begin
    if (rst) begin
      outputs_reg  = CFG_W'(1);
      channels_reg = CFG_W'(1);
      for (int n = 0; n < TABLE_DIM; n++) acc_bank[n] = '0;
      sums_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_out_beat();
      if (cfg_we) begin
        if (cfg_index == REG_OUTPUTS) outputs_reg = cfg_data;
        else if (cfg_index == REG_CHANNELS) channels_reg = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) take_in_beat();
    end
    sums_pending <= sums_due.size();
  end

endmodule

// ===== tb/tb_pointwise_channel_mix.sv =====
`timescale 1ns / 1ps

module tb_pointwise_channel_mix;

  import pcm_pkg::*;

  localparam int ITEM_GOAL     = 350;
  localparam int SETTLE_CYCLES = 200;
  localparam int TABLE_DIM     = 64;
  localparam int WEIGHT_BUDGET = 128;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [47:0]          m_axis_tdata;
  logic                 m_axis_tlast;

  int mismatches;
  int sums_pending;
  int items_sent = 0;
  int eff_outputs = 1;
  int eff_channels = 1;
  int rx_hold = 0;
  bit steady_tx = 1'b0;
  bit steady_rx = 1'b0;
  bit w_written [TABLE_DIM][TABLE_DIM];
  logic [CFG_W-1:0] next_outs;
  logic [CFG_W-1:0] next_chans;

  pointwise_channel_mix i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  pcm_sum_checker i_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .mismatches(mismatches),
    .sums_pending(sums_pending)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  // Idle gap lengths: mostly short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 18) return $urandom_range(4, 8);
    return $urandom_range(16, 40);
  endfunction

  // Weight and sample values lean toward the extremes.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Register values: mostly small, sometimes zero, the maximum or beyond it.
  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CFG_W'(TABLE_DIM);
      2:       return CFG_W'($urandom_range(65, 127));
      3:       return CFG_W'($urandom_range(7, 63));
      default: return CFG_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic int clamp_count(input logic [CFG_W-1:0] r);
    if (r == '0) return 1;
    if (int'(r) > TABLE_DIM) return TABLE_DIM;
    return int'(r);
  endfunction

  // Result side: tready drops for random stretches, with calm periods.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) steady_rx = !steady_rx;
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady_rx && $urandom_range(0, 2) == 0) rx_hold = pick_gap();
    end
  end

  // Present one input beat after an optional gap and wait until it is taken.
  task automatic send_beat(input logic op, input logic [IDX_W-1:0] oi,
                           input logic [IDX_W-1:0] ii, input logic [VALUE_W-1:0] val);
    int gap;
    gap = 0;
    if (!steady_tx && $urandom_range(0, 1) == 0) gap = pick_gap();
    if ($urandom_range(0, 99) == 0) steady_tx = !steady_tx;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0000, val, ii, oi};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic put_weight(input int oi, input int ii, input logic [VALUE_W-1:0] val);
    send_beat(OP_WEIGHT, IDX_W'(oi), IDX_W'(ii), val);
    w_written[oi][ii] = 1'b1;
    items_sent++;
  endtask

  // The output index of a sample is ignored, so it carries random bits. Every
  // weight that the sample reads is written first if it never was.
  task automatic put_sample(input int ii, input logic [VALUE_W-1:0] val);
    if (ii < eff_channels) begin
      for (int o = 0; o < eff_outputs; o++)
        if (!w_written[o][ii]) put_weight(o, ii, pick_value());
    end
    send_beat(OP_SAMPLE, IDX_W'($urandom_range(0, 63)), IDX_W'(ii), val);
    items_sent++;
  endtask

  // A sample beyond the channel count; the block drops it.
  task automatic put_stray_sample();
    if (eff_channels < TABLE_DIM) begin
      send_beat(OP_SAMPLE, IDX_W'($urandom), IDX_W'($urandom_range(eff_channels, 63)),
                pick_value());
      items_sent++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_OUTPUTS) eff_outputs = clamp_count(val);
    else eff_channels = clamp_count(val);
  endtask

  task automatic configure(input logic [CFG_W-1:0] outs, input logic [CFG_W-1:0] chans);
    write_reg(REG_OUTPUTS, outs);
    write_reg(REG_CHANNELS, chans);
  endtask

  // Stop the input, wait for every sum due, then let a sample without a
  // result work its way through the pipeline.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sums_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One pixel of random content; most are well formed, the rest repeat or
  // skip channels, stop short, or carry only noise.
  task automatic random_pixel();
    int kind;
    int k;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      for (int c = 0; c < eff_channels; c++) begin
        case ($urandom_range(0, 11))
          0:       put_weight($urandom_range(0, 63), $urandom_range(0, 63), pick_value());
          1:       put_stray_sample();
          default: ;
        endcase
        put_sample(c, pick_value());
      end
    end else if (kind == 7) begin
      k = $urandom_range(1, eff_channels + 2);
      repeat (k - 1) put_sample($urandom_range(0, eff_channels - 1), pick_value());
      put_sample(eff_channels - 1, pick_value());
    end else if (kind == 8) begin
      k = $urandom_range(0, eff_channels - 1);
      for (int c = 0; c < k; c++) put_sample(c, pick_value());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1) == 0) put_stray_sample();
        else put_weight($urandom_range(0, 63), $urandom_range(0, 63), pick_value());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Three outputs over two channels with extreme weights and samples,
    // a dropped sample, repeated channels and a pixel ended by its last channel.
    configure(CFG_W'(3), CFG_W'(2));
    put_weight(0, 0, 16'h8000);
    put_weight(0, 1, 16'h8000);
    put_weight(1, 0, 16'h7fff);
    put_weight(1, 1, 16'h8000);
    put_weight(2, 0, 16'hffff);
    put_weight(2, 1, 16'h7fff);
    put_weight(63, 63, 16'h7fff);
    send_beat(OP_SAMPLE, IDX_W'(63), IDX_W'(63), 16'h8000);
    put_sample(0, 16'h8000);
    put_sample(1, 16'h8000);
    put_sample(0, 16'h7fff);
    put_sample(1, 16'h7fff);
    put_sample(0, 16'h1234);
    put_sample(0, 16'hedcb);
    put_sample(1, 16'h0001);
    put_sample(1, 16'hffff);
    settle();

    // Zero counts behave as one.
    configure('0, '0);
    put_sample(0, 16'h7fff);
    send_beat(OP_SAMPLE, '0, IDX_W'(1), 16'h7fff);
    settle();

    // Counts above the table saturate; the last channel alone ends the pixel.
    configure(CFG_W'(127), CFG_W'(127));
    put_sample(63, 16'h8000);
    settle();

    // The same channel over and over drives the accumulator past its range.
    configure(CFG_W'(1), CFG_W'(2));
    put_weight(0, 0, 16'h8000);
    repeat (130) put_sample(0, 16'h8000);
    put_sample(1, 16'h0000);
    settle();

    // Random phases, each under a new pair of counts. A pair with many outputs
    // gets few channels, so that the weights a phase needs stay few.
    while (items_sent < ITEM_GOAL) begin
      next_outs  = pick_count();
      next_chans = pick_count();
      if (clamp_count(next_outs) * clamp_count(next_chans) > WEIGHT_BUDGET)
        next_chans = CFG_W'($urandom_range(1, WEIGHT_BUDGET / clamp_count(next_outs)));
      configure(next_outs, next_chans);
      repeat ($urandom_range(1, 4)) random_pixel();
      settle();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pcm_pkg.sv
sv/pcm_ram.sv
sv/pcm_mac.sv
sv/pcm_out.sv
sv/pointwise_channel_mix.sv
tb/pcm_sum_checker.sv
tb/tb_pointwise_channel_mix.sv
